[rtl/pll_coefficient_search_defines.svh]
// assertion macros for the pll coefficient search rtl
`ifndef PLL_COEFFICIENT_SEARCH_DEFINES_SVH
`define PLL_COEFFICIENT_SEARCH_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define PCS_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("pcs assertion failed");

// antecedent in this cycle implies consequent in this cycle
`define PCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pcs implication failed");

// antecedent in this cycle implies consequent in the next cycle
`define PCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pcs next-cycle implication failed");

`endif

[rtl/pcs_pkg.sv]
// types and constants of the pll coefficient search block
package pcs_pkg;

  localparam int unsigned TargetW  = 20;
  localparam int unsigned VclkW    = 21;
  localparam int unsigned CrystalW = 16;
  localparam int unsigned RefW     = 18;
  localparam int unsigned VcoW     = 20;
  localparam int unsigned ProdW    = 27;
  localparam int unsigned MW       = 4;
  localparam int unsigned NW       = 8;
  localparam int unsigned PW       = 3;
  localparam int unsigned ClkOutW  = 25;
  localparam int unsigned WordW    = 19;
  localparam int unsigned Word2W   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 96;

  localparam logic [CfgIdxW-1:0] CfgCrystal  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEarly    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxVco   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTwoStage = 3'd3;

  localparam logic [CrystalW-1:0] CrystalReset   = 16'd14318;
  localparam logic [CrystalW-1:0] CrystalSpecial = 16'd14318;
  localparam logic [VcoW-1:0]     MaxVcoReset    = 20'd350000;
  localparam logic [VcoW-1:0]     SsVcoMin       = 20'd128000;
  localparam logic [VcoW-1:0]     TsVcoMin       = 20'd400000;
  localparam logic [VcoW-1:0]     TsVcoMax       = 20'd1000000;
  localparam logic [NW-1:0]       TsNMin         = 8'd5;
  localparam logic [Word2W-1:0]   SecondWord     = 32'h8000_0401;

  // commands from the controller to the datapath
  typedef struct packed {
    logic setup;
    logic p_inc;
    logic m_init;
    logic m_inc;
    logic mul1;
    logic div1;
    logic mul2;
    logic div2;
    logic calc;
    logic upd;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic ref_zero;
    logic window_ok;
    logic p_last;
    logic m_last;
    logic n_ok;
    logic div_busy;
  } sts_t;

endpackage

[rtl/pcs_div.sv]
// restoring divider, one quotient bit per cycle
module pcs_div #(
  parameter int unsigned DividendW = pcs_pkg::ProdW,
  parameter int unsigned DivisorW  = pcs_pkg::RefW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = (DividendW > 1) ? $clog2(DividendW) : 1;

  logic                 busy_q;
  logic [CntW-1:0]      cnt_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  dsr_q;

  logic [DivisorW:0] shifted;
  logic [DivisorW:0] diff;
  logic              take;

  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign take    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DividendW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DivisorW-1:0] : shifted[DivisorW-1:0];
      quo_q <= {quo_q[DividendW-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[rtl/pcs_dp.sv]
// datapath: configuration, loop counters, products, divider and best candidate
module pcs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [pcs_pkg::TargetW-1:0]   target_i,
  input  logic                          vclk_dbl_i,
  input  pcs_pkg::cmd_t                 cmd_i,
  output pcs_pkg::sts_t                 sts_o,
  output logic [pcs_pkg::OutDataW-1:0]  out_data_o
);

  localparam int unsigned ProdW = pcs_pkg::ProdW;
  localparam int unsigned RefW  = pcs_pkg::RefW;
  localparam int unsigned MW    = pcs_pkg::MW;
  localparam int unsigned NW    = pcs_pkg::NW;
  localparam int unsigned PW    = pcs_pkg::PW;
  localparam int unsigned VclkW = pcs_pkg::VclkW;
  localparam int unsigned VcoW  = pcs_pkg::VcoW;

  logic [pcs_pkg::CrystalW-1:0] crystal_q;
  logic                         early_q;
  logic [VcoW-1:0]              max_vco_q;
  logic                         two_q;

  logic [VclkW-1:0] vclk_q;
  logic [PW-1:0]    p_q;
  logic [MW-1:0]    m_q;
  logic [ProdW-1:0] prod_q;
  logic [NW-1:0]    n_q;
  logic [ProdW-1:0] f_q;
  logic [ProdW-1:0] d_q;

  logic             hit_q;
  logic [MW-1:0]    best_m_q;
  logic [NW-1:0]    best_n_q;
  logic [PW-1:0]    best_p_q;
  logic [ProdW-1:0] best_f_q;
  logic [ProdW-1:0] best_d_q;
  logic [pcs_pkg::OutDataW-1:0] out_q;

  // search limits follow the registers; the user must hold them still during a search (not enforced)
  logic [RefW-1:0]  ref_w;
  logic [MW-1:0]    m_lo_w;
  logic [MW-1:0]    m_hi_w;
  logic [PW-1:0]    p_hi_w;
  logic [VcoW-1:0]  vco_lo_w;
  logic [VcoW-1:0]  vco_hi_w;
  logic [NW-1:0]    n_lo_w;

  always_comb begin
    if (two_q) begin
      ref_w    = {crystal_q, 2'b00};
      m_lo_w   = MW'(1);
      m_hi_w   = MW'(13);
      p_hi_w   = PW'(6);
      vco_lo_w = pcs_pkg::TsVcoMin;
      vco_hi_w = pcs_pkg::TsVcoMax;
      n_lo_w   = pcs_pkg::TsNMin;
    end else begin
      ref_w = {2'b00, crystal_q};
      if (crystal_q == pcs_pkg::CrystalSpecial) begin
        m_lo_w = MW'(8);
        m_hi_w = MW'(14) - {{(MW-1){1'b0}}, early_q};
      end else begin
        m_lo_w = MW'(7);
        m_hi_w = MW'(13) - {{(MW-1){1'b0}}, early_q};
      end
      p_hi_w   = PW'(4) - {{(PW-1){1'b0}}, early_q};
      vco_lo_w = pcs_pkg::SsVcoMin;
      vco_hi_w = max_vco_q;
      n_lo_w   = '0;
    end
  end

  logic [ProdW-1:0]      vco_w;
  logic                  window_ok;
  logic [MW+VcoW-1:0]    mul1_w;
  logic [RefW+NW-1:0]    mul2_w;
  logic [ProdW-1:0]      quot_w;
  logic                  div_busy;
  logic [RefW-1:0]       divisor_w;
  logic [ProdW-1:0]      f_w;
  logic [ProdW-1:0]      vclk_x;
  logic [ProdW-1:0]      d_w;
  logic                  better;

  assign vco_w     = {{(ProdW-VclkW){1'b0}}, vclk_q} << p_q;
  assign window_ok = (vco_w >= {{(ProdW-VcoW){1'b0}}, vco_lo_w}) &&
                     (vco_w <= {{(ProdW-VcoW){1'b0}}, vco_hi_w});
  // inside the window the vco fits the narrow operand
  assign mul1_w    = vco_w[VcoW-1:0] * m_q;
  assign mul2_w    = ref_w * quot_w[NW-1:0];
  assign divisor_w = cmd_i.div2 ? {{(RefW-MW){1'b0}}, m_q} : ref_w;

  pcs_div #(
    .DividendW(ProdW),
    .DivisorW (RefW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div1 | cmd_i.div2),
    .dividend_i(prod_q),
    .divisor_i (divisor_w),
    .busy_o    (div_busy),
    .quotient_o(quot_w)
  );

  assign f_w    = quot_w >> p_q;
  assign vclk_x = {{(ProdW-VclkW){1'b0}}, vclk_q};
  assign d_w    = (f_w > vclk_x) ? (f_w - vclk_x) : (vclk_x - f_w);
  assign better = !hit_q || (d_q < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q <= pcs_pkg::CrystalReset;
      early_q   <= 1'b0;
      max_vco_q <= pcs_pkg::MaxVcoReset;
      two_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcs_pkg::CfgCrystal:  crystal_q <= cfg_wdata_i[pcs_pkg::CrystalW-1:0];
        pcs_pkg::CfgEarly:    early_q   <= cfg_wdata_i[0];
        pcs_pkg::CfgMaxVco:   max_vco_q <= cfg_wdata_i[VcoW-1:0];
        pcs_pkg::CfgTwoStage: two_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.setup) begin
      hit_q <= 1'b0;
    end else if (cmd_i.upd && better) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      vclk_q <= vclk_dbl_i ? {target_i, 1'b0} : {1'b0, target_i};
      p_q    <= '0;
    end else if (cmd_i.p_inc) begin
      p_q <= p_q + 1'b1;
    end
    if (cmd_i.m_init) begin
      m_q <= m_lo_w;
    end else if (cmd_i.m_inc) begin
      m_q <= m_q + 1'b1;
    end
    if (cmd_i.mul1) begin
      prod_q <= {{(ProdW-MW-VcoW){1'b0}}, mul1_w};
    end else if (cmd_i.mul2) begin
      prod_q <= {{(ProdW-RefW-NW){1'b0}}, mul2_w};
    end
    // n is taken while the first quotient still sits in the divider
    if (cmd_i.mul2) begin
      n_q <= quot_w[NW-1:0];
    end
    if (cmd_i.calc) begin
      f_q <= f_w;
      d_q <= d_w;
    end
    if (cmd_i.upd && better) begin
      best_m_q <= m_q;
      best_n_q <= n_q;
      best_p_q <= p_q;
      best_f_q <= f_q;
      best_d_q <= d_q;
    end
    if (cmd_i.out_load) begin
      if (hit_q) begin
        out_q <= {4'b0000,
                  two_q ? pcs_pkg::SecondWord : {pcs_pkg::Word2W{1'b0}},
                  best_p_q, best_n_q, 4'b0000, best_m_q,
                  best_f_q[pcs_pkg::ClkOutW-1:0],
                  best_p_q, best_n_q, best_m_q, 1'b1};
      end else begin
        out_q <= '0;
      end
    end
  end

  assign sts_o.ref_zero  = (crystal_q == '0);
  assign sts_o.window_ok = window_ok;
  assign sts_o.p_last    = (p_q == p_hi_w);
  assign sts_o.m_last    = (m_q == m_hi_w);
  assign sts_o.n_ok      = (quot_w[ProdW-1:NW] == '0) && (quot_w[NW-1:0] >= n_lo_w);
  assign sts_o.div_busy  = div_busy;

  assign out_data_o = out_q;

endmodule

[rtl/pcs_ctrl.sv]
// controller state machine of the pll coefficient search
`include "pll_coefficient_search_defines.svh"

module pcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  pcs_pkg::sts_t sts_i,
  output pcs_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PCHK,
    ST_MUL1,
    ST_DIV1S,
    ST_DIV1W,
    ST_NCHK,
    ST_MUL2,
    ST_DIV2S,
    ST_DIV2W,
    ST_CALC,
    ST_UPD,
    ST_MNEXT,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic          out_valid_q;
  logic          out_free;
  pcs_pkg::cmd_t cmd;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.setup = 1'b1;
          state_d   = sts_i.ref_zero ? ST_DONE : ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (sts_i.window_ok) begin
          cmd.m_init = 1'b1;
          state_d    = ST_MUL1;
        end else if (sts_i.p_last) begin
          state_d = ST_DONE;
        end else begin
          cmd.p_inc = 1'b1;
        end
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_d  = ST_DIV1S;
      end
      ST_DIV1S: begin
        cmd.div1 = 1'b1;
        state_d  = ST_DIV1W;
      end
      ST_DIV1W: begin
        if (!sts_i.div_busy) begin
          state_d = ST_NCHK;
        end
      end
      ST_NCHK: begin
        state_d = sts_i.n_ok ? ST_MUL2 : ST_MNEXT;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_d  = ST_DIV2S;
      end
      ST_DIV2S: begin
        cmd.div2 = 1'b1;
        state_d  = ST_DIV2W;
      end
      ST_DIV2W: begin
        if (!sts_i.div_busy) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        state_d = ST_MNEXT;
      end
      ST_MNEXT: begin
        if (!sts_i.m_last) begin
          cmd.m_inc = 1'b1;
          state_d   = ST_MUL1;
        end else if (sts_i.p_last) begin
          state_d = ST_DONE;
        end else begin
          cmd.p_inc = 1'b1;
          state_d   = ST_PCHK;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign cmd_o         = cmd;

  `PCS_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, cmd.div1 || cmd.div2, !sts_i.div_busy)
  `PCS_ASSERT_IMP(a_load_no_overwrite, clk_i, rst_ni, cmd.out_load, !out_valid_q || m_axis_tready)
  `PCS_ASSERT_IMP(a_m_loop_in_window, clk_i, rst_ni, cmd.m_init, sts_i.window_ok)
  `PCS_ASSERT_NXT(a_load_gives_valid, clk_i, rst_ni, cmd.out_load, out_valid_q)

endmodule

[rtl/pll_coefficient_search.sv]
// pll coefficient search: top level joining controller and datapath
//
// Input channel s_axis: one transfer carries a wanted clock in kHz and the
// scan-doubling flag. The block then scans the post-divider shift P (outer)
// and reference divider M (inner) and finds N with a shared restoring
// divider that yields one quotient bit per cycle.
// Output channel m_axis: one transfer per input with found, M, N, P, the
// achieved clock, the packed pll word and the second-stage word; all zero
// when no candidate fits.
// Each shift P is checked against the vco window; each (P, M) candidate
// inside it runs one division for N, and a candidate whose N is in range
// runs a second division for the achieved clock. At most 28 candidates
// pass the window.
// Items are taken one at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new item is accepted while
// the previous result still waits; a stalled receiver holds the search at
// its last step until the register frees up.
// Reset restores the configuration defaults and empties the output.
// Configuration writes go through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must make them while idle (not enforced).
module pll_coefficient_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [19:0] target_khz, [23:20] zero
  input  logic [pcs_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] scan doubling flag
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] found, [4:1] m_div, [12:5] n_mult, [15:13] p_shift,
  // [40:16] clock_out_khz, [59:41] pll_word, [91:60] second_pll_word, [95:92] zero
  output logic [pcs_pkg::OutDataW-1:0]  m_axis_tdata
);

  pcs_pkg::cmd_t cmd;
  pcs_pkg::sts_t sts;

  pcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  pcs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .target_i     (s_axis_tdata[pcs_pkg::TargetW-1:0]),
    .vclk_dbl_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_data_o   (m_axis_tdata)
  );

endmodule

[tb/pll_coefficient_search_tb.sv]
// self-checking testbench for the pll coefficient search block
module pll_coefficient_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pcs_pkg::CfgIdxW-1:0] CfgUnused = 3'd5;
  localparam int unsigned IdleCycles = 16;
  localparam int unsigned StallCycles = 3000;

  typedef struct packed {
    logic [pcs_pkg::TargetW-1:0] target;
    logic                        dscan;
  } clock_req_t;

  typedef struct packed {
    logic                        found;
    logic [pcs_pkg::MW-1:0]      m_div;
    logic [pcs_pkg::NW-1:0]      n_mult;
    logic [pcs_pkg::PW-1:0]      p_shift;
    logic [pcs_pkg::ClkOutW-1:0] clk_out;
    logic [pcs_pkg::WordW-1:0]   word;
    logic [pcs_pkg::Word2W-1:0]  word2;
  } divider_set_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [pcs_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [pcs_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [pcs_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                         s_axis_tuser = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [pcs_pkg::OutDataW-1:0] m_axis_tdata;

  pll_coefficient_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // local copy of the configuration registers
  logic [pcs_pkg::CrystalW-1:0] crystal_khz = pcs_pkg::CrystalReset;
  logic                         early_chip = 1'b0;
  logic [pcs_pkg::VcoW-1:0]     max_vco_khz = pcs_pkg::MaxVcoReset;
  logic                         two_stage = 1'b0;

  clock_req_t   req_q[$];
  divider_set_t dividers_q[$];
  int           errors = 0;
  bit           req_taken = 1'b0;
  bit           steady = 1'b0;
  int           stall_reqs = 0;
  int           stall_seen = 0;
  int           stall_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic divider_set_t search_dividers(logic [pcs_pkg::TargetW-1:0] target,
                                                   logic dscan);
    logic [63:0] vclk, refk, vco, n, f, d, best_d, vlo, vhi, nlo;
    int unsigned mlo, mhi, phi;
    divider_set_t r;
    bit hit;
    r = '0;
    hit = 1'b0;
    best_d = '0;
    vclk = 64'(target);
    if (dscan) vclk = vclk * 2;
    if (two_stage) begin
      refk = 64'(crystal_khz) << 2;
      mlo = 1; mhi = 13; phi = 6;
      vlo = 64'(pcs_pkg::TsVcoMin); vhi = 64'(pcs_pkg::TsVcoMax);
      nlo = 64'(pcs_pkg::TsNMin);
    end else begin
      refk = 64'(crystal_khz);
      if (crystal_khz == pcs_pkg::CrystalSpecial) begin
        mlo = 8; mhi = 14 - early_chip;
      end else begin
        mlo = 7; mhi = 13 - early_chip;
      end
      phi = 4 - early_chip;
      vlo = 64'(pcs_pkg::SsVcoMin); vhi = 64'(max_vco_khz); nlo = 0;
    end
    if (refk != 0) begin
      for (int unsigned p = 0; p <= phi; p++) begin
        vco = vclk << p;
        if (vco < vlo || vco > vhi) continue;
        for (int unsigned m = mlo; m <= mhi; m++) begin
          n = (vco * m) / refk;
          if (n < nlo || n > 255) continue;
          f = ((refk * n) / m) >> p;
          d = (f > vclk) ? f - vclk : vclk - f;
          if (!hit || d < best_d) begin
            hit = 1'b1;
            best_d = d;
            r.m_div = pcs_pkg::MW'(m);
            r.n_mult = pcs_pkg::NW'(n);
            r.p_shift = pcs_pkg::PW'(p);
            r.clk_out = pcs_pkg::ClkOutW'(f);
            r.word = pcs_pkg::WordW'(m + (n << 8) + (p << 16));
          end
        end
      end
    end
    if (hit) begin
      r.found = 1'b1;
      r.word2 = two_stage ? pcs_pkg::SecondWord : '0;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // input transfers: predict the result; output transfers: compare with the oldest prediction
  always @(posedge clk_i) begin
    divider_set_t exp_d;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        dividers_q.push_back(search_dividers(s_axis_tdata[pcs_pkg::TargetW-1:0],
                                             s_axis_tuser));
        void'(req_q.pop_front());
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (dividers_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          exp_d = dividers_q.pop_front();
          check_field("found", exp_d.found, m_axis_tdata[0]);
          check_field("m_div", exp_d.m_div, m_axis_tdata[4:1]);
          check_field("n_mult", exp_d.n_mult, m_axis_tdata[12:5]);
          check_field("p_shift", exp_d.p_shift, m_axis_tdata[15:13]);
          check_field("clock_out_khz", exp_d.clk_out, m_axis_tdata[40:16]);
          check_field("pll_word", exp_d.word, m_axis_tdata[59:41]);
          check_field("second_pll_word", exp_d.word2, m_axis_tdata[91:60]);
        end
      end
    end
  end

  // sender: holds an item until its transfer, then offers the next or idles
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (req_q.size() > 0 && (steady || $urandom_range(99) >= 13)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(pcs_pkg::InDataW-pcs_pkg::TargetW){1'b0}}, req_q[0].target};
        s_axis_tuser  <= req_q[0].dscan;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // receiver: random backpressure plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      stall_left = StallCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 13);
    end
  end

  task automatic write_reg(logic [pcs_pkg::CfgIdxW-1:0] idx,
                           logic [pcs_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      pcs_pkg::CfgCrystal:  crystal_khz = data[pcs_pkg::CrystalW-1:0];
      pcs_pkg::CfgEarly:    early_chip = data[0];
      pcs_pkg::CfgMaxVco:   max_vco_khz = data[pcs_pkg::VcoW-1:0];
      pcs_pkg::CfgTwoStage: two_stage = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_req(logic [pcs_pkg::TargetW-1:0] target, logic dscan);
    clock_req_t r;
    r.target = target;
    r.dscan = dscan;
    req_q.push_back(r);
  endtask

  function automatic logic [pcs_pkg::TargetW-1:0] pick_target();
    int unsigned sel;
    int unsigned hi;
    sel = $urandom_range(99);
    hi = two_stage ? 1000000 : ((max_vco_khz > 8000) ? max_vco_khz : 8000);
    if (sel < 12) return pcs_pkg::TargetW'($urandom);
    if (sel < 22) begin
      case ($urandom_range(7))
        0: return '0;
        1: return '1;
        2: return pcs_pkg::TargetW'(1000000);
        3: return pcs_pkg::TargetW'(128000);
        4: return pcs_pkg::TargetW'(400000);
        5: return pcs_pkg::TargetW'(350000);
        6: return pcs_pkg::TargetW'(8000);
        default: return pcs_pkg::TargetW'(6250);
      endcase
    end
    return pcs_pkg::TargetW'($urandom_range(hi, 4000));
  endfunction

  task automatic queue_random(int count);
    repeat (count) queue_req(pick_target(), $urandom_range(3) == 0);
  endtask

  // wait until every item is sent and every result is back, then let the block settle
  task automatic drain();
    while (req_q.size() > 0 || s_axis_tvalid || dividers_q.size() > 0 || stall_left > 0)
      @(posedge clk_i);
    repeat (IdleCycles) @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: single stage, special crystal
    queue_req('0, 1'b0);
    queue_req('1, 1'b1);
    queue_req(pcs_pkg::TargetW'(1000000), 1'b0);
    queue_req(pcs_pkg::TargetW'(1000000), 1'b1);
    queue_req(pcs_pkg::TargetW'(25175), 1'b0);
    queue_req(pcs_pkg::TargetW'(28322), 1'b0);
    queue_req(pcs_pkg::TargetW'(31500), 1'b1);
    queue_req(pcs_pkg::TargetW'(40000), 1'b0);
    queue_req(pcs_pkg::TargetW'(65000), 1'b0);
    queue_req(pcs_pkg::TargetW'(108000), 1'b0);
    queue_req(pcs_pkg::TargetW'(128000), 1'b0);
    queue_req(pcs_pkg::TargetW'(127999), 1'b0);
    queue_req(pcs_pkg::TargetW'(64000), 1'b1);
    queue_req(pcs_pkg::TargetW'(175000), 1'b1);
    queue_req(pcs_pkg::TargetW'(350000), 1'b0);
    queue_req(pcs_pkg::TargetW'(350001), 1'b0);
    queue_req(pcs_pkg::TargetW'(8000), 1'b0);
    queue_req(pcs_pkg::TargetW'(7999), 1'b0);
    queue_req(pcs_pkg::TargetW'(1), 1'b1);
    queue_random(12);
    drain();
    stall_reqs++;
    queue_random(14);
    drain();

    // early chip, crystal written with junk above bit 15
    write_reg(pcs_pkg::CfgEarly, 20'h3);
    write_reg(pcs_pkg::CfgCrystal, 20'hA37EE);
    queue_req(pcs_pkg::TargetW'(100000), 1'b0);
    queue_req(pcs_pkg::TargetW'(50000), 1'b1);
    queue_req(pcs_pkg::TargetW'(21875), 1'b0);
    queue_random(15);
    drain();

    // wide vco window, no gaps on either side
    steady = 1'b1;
    write_reg(pcs_pkg::CfgCrystal, 20'd13500);
    write_reg(pcs_pkg::CfgEarly, 20'h2);
    write_reg(pcs_pkg::CfgMaxVco, 20'd1000000);
    queue_req(pcs_pkg::TargetW'(1000000), 1'b0);
    queue_req(pcs_pkg::TargetW'(500000), 1'b1);
    queue_random(12);
    drain();
    steady = 1'b0;

    // empty vco window
    write_reg(pcs_pkg::CfgCrystal, 20'd27000);
    write_reg(pcs_pkg::CfgEarly, 20'd1);
    write_reg(pcs_pkg::CfgMaxVco, 20'd127999);
    queue_random(8);
    drain();

    // all-ones vco limit, low crystal, write to a missing register
    write_reg(pcs_pkg::CfgMaxVco, 20'hFFFFF);
    write_reg(pcs_pkg::CfgCrystal, 20'd1000);
    write_reg(pcs_pkg::CfgEarly, 20'd0);
    write_reg(CfgUnused, 20'h5A5A5);
    queue_req(pcs_pkg::TargetW'(1000000), 1'b1);
    queue_random(12);
    drain();

    // two-stage rules
    write_reg(pcs_pkg::CfgTwoStage, 20'd1);
    write_reg(pcs_pkg::CfgCrystal, 20'd14318);
    queue_req('0, 1'b0);
    queue_req(pcs_pkg::TargetW'(25175), 1'b0);
    queue_req(pcs_pkg::TargetW'(6250), 1'b0);
    queue_req(pcs_pkg::TargetW'(400000), 1'b0);
    queue_req(pcs_pkg::TargetW'(1000000), 1'b0);
    queue_req(pcs_pkg::TargetW'(500000), 1'b1);
    queue_req('1, 1'b0);
    queue_random(12);
    drain();

    write_reg(pcs_pkg::CfgCrystal, 20'd65535);
    queue_random(6);
    drain();
    write_reg(pcs_pkg::CfgCrystal, 20'd1000);
    write_reg(pcs_pkg::CfgTwoStage, 20'h2);
    write_reg(pcs_pkg::CfgTwoStage, 20'h3);
    queue_random(7);
    drain();

    // zero crystal in both modes, then a zero vco limit
    write_reg(pcs_pkg::CfgCrystal, 20'd0);
    queue_req(pcs_pkg::TargetW'(100000), 1'b0);
    queue_req(pcs_pkg::TargetW'(25175), 1'b1);
    queue_random(2);
    drain();
    write_reg(pcs_pkg::CfgTwoStage, 20'd0);
    queue_req(pcs_pkg::TargetW'(100000), 1'b0);
    queue_random(2);
    drain();
    write_reg(pcs_pkg::CfgCrystal, 20'd14318);
    write_reg(pcs_pkg::CfgMaxVco, 20'd0);
    queue_req(pcs_pkg::TargetW'(100000), 1'b0);
    queue_random(2);
    drain();

    repeat (IdleCycles) @(negedge clk_i);
    if (errors == 0 && dividers_q.size() == 0) begin
      $display("pll_coefficient_search_tb: done, clean");
    end else begin
      $display("pll_coefficient_search_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("pll_coefficient_search_tb: done, errors");
    $finish;
  end

endmodule
